@@ sv/assert_macros.svh @@
// Assertion macros for the RTL files; tdoa_measurement_engine includes them.
// Empty bodies when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPL(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) else $error("assertion failed");
`else
`define ASSERT_IMPL(label, clk, rst, prop)
`define ASSERT_NEXT(label, clk, rst, a, b)
`endif
`endif

@@ sv/tdoa_pkg.sv @@
// Package for the TDOA measurement engine: controller states and the
// command/status structs between controller and datapath. No dependencies.
`default_nettype none
package tdoa_pkg;
  typedef enum logic [2:0] {
    ST_IDLE, ST_DIV, ST_MUL1, ST_MUL2, ST_MUL3, ST_OUT
  } state_t;

  typedef struct packed {
    logic load;      // latch item, start item processing
    logic div_step;  // dividend load or one quotient bit
    logic mul1;      // tw * ratio
    logic mul2;      // saturate time difference
    logic mul3;      // metres product
    logic commit;    // update stored state, fill output
  } cmd_t;

  typedef struct packed {
    logic need_work;  // last slot of an in-range anchor
    logic div_done;
  } stat_t;

  localparam logic [31:0] SCALE_RESET = 32'd20150973;
endpackage
`default_nettype wire

@@ sv/tdoa_ctrl.sv @@
// Controller state machine for the TDOA engine.
// Depends on tdoa_pkg.
`default_nettype none
module tdoa_ctrl (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           in_fire,
  input  wire logic           out_free,
  input  wire tdoa_pkg::stat_t stat,
  output tdoa_pkg::cmd_t      cmd,
  output logic                busy,
  output logic                out_set
);
  tdoa_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= tdoa_pkg::ST_IDLE;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    cmd = '0;
    out_set = 1'b0;
    busy = (state != tdoa_pkg::ST_IDLE);
    unique case (state)
      tdoa_pkg::ST_IDLE: begin
        cmd.load = in_fire;
        if (in_fire && stat.need_work) state_next = tdoa_pkg::ST_DIV;
      end
      tdoa_pkg::ST_DIV: begin
        cmd.div_step = 1'b1;
        if (stat.div_done) state_next = tdoa_pkg::ST_MUL1;
      end
      tdoa_pkg::ST_MUL1: begin
        cmd.mul1 = 1'b1;
        state_next = tdoa_pkg::ST_MUL2;
      end
      tdoa_pkg::ST_MUL2: begin
        cmd.mul2 = 1'b1;
        state_next = tdoa_pkg::ST_MUL3;
      end
      tdoa_pkg::ST_MUL3: begin
        cmd.mul3 = 1'b1;
        state_next = tdoa_pkg::ST_OUT;
      end
      tdoa_pkg::ST_OUT: begin
        if (out_free) begin
          cmd.commit = 1'b1;
          out_set = 1'b1;
          state_next = tdoa_pkg::ST_IDLE;
        end
      end
      default: state_next = tdoa_pkg::ST_IDLE;
    endcase
  end
endmodule
`default_nettype wire

@@ sv/tdoa_dp.sv @@
// Datapath for the TDOA engine: per-anchor tables, slot latches, serial
// divider, multiplies and saturation. Depends on tdoa_pkg.
`default_nettype none
module tdoa_dp #(
  parameter int ANCHORS = 8
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire tdoa_pkg::cmd_t  cmd,
  output tdoa_pkg::stat_t      stat,
  input  wire logic [31:0]     scale,
  input  wire logic [2:0]      anchor_id,
  input  wire logic [7:0]      packet_seq,
  input  wire logic [31:0]     arrival_time,
  input  wire logic [2:0]      slot,
  input  wire logic [31:0]     slot_timestamp,
  input  wire logic [15:0]     slot_distance,
  input  wire logic            last_slot,
  output logic [80:0]          result
);
  localparam int AW = (ANCHORS > 1) ? $clog2(ANCHORS) : 1;

  logic [7:0]  stored_seq [ANCHORS];
  logic [31:0] stored_tx_time [ANCHORS];
  logic [31:0] stored_arrival [ANCHORS];
  logic [31:0] clock_ratio [ANCHORS];
  logic [2:0]  previous_anchor;
  logic [31:0] own_tx_latch, ref_rx_latch;
  logic [15:0] ref_dist_latch;

  logic [2:0]  an;
  logic [7:0]  seq;
  logic [31:0] arrival;
  logic        in_range;
  logic [AW-1:0] an_i, ar_i;
  logic        seq_ok;
  logic [31:0] f_t;
  logic [62:0] rem;
  logic [62:0] dividend;
  logic [62:0] quot;
  logic [5:0]  div_cnt;
  logic [31:0] new_ratio;
  logic [63:0] prod;
  logic signed [35:0] tdiff_wide;
  logic signed [31:0] tdiff;
  logic [63:0] mprod;
  logic        tneg;

  assign in_range = ({2'b0, anchor_id} < 5'(ANCHORS));
  assign stat.need_work = in_range && last_slot;
  assign an_i = AW'(an);
  assign ar_i = AW'(previous_anchor);

  // ratio used downstream: new one if updated
  logic [31:0] ratio_use;
  assign ratio_use = seq_ok ? new_ratio : clock_ratio[an_i];

  always_comb begin
    if (f_t == 32'd0) new_ratio = '1;
    else if (|quot[62:32]) new_ratio = '1;
    else new_ratio = quot[31:0];
  end
  assign stat.div_done = (div_cnt == 6'd63);

  logic [62:0] shifted;
  assign shifted = {rem[61:0], dividend[62]};

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < ANCHORS; i++) begin
        stored_seq[i] <= '0;
        stored_tx_time[i] <= '0;
        stored_arrival[i] <= '0;
        clock_ratio[i] <= '0;
      end
      previous_anchor <= '0;
      own_tx_latch <= '0;
      ref_rx_latch <= '0;
      ref_dist_latch <= '0;
    end else begin
      if (cmd.load && in_range) begin
        if (slot == anchor_id) own_tx_latch <= slot_timestamp;
        if (slot == previous_anchor) begin
          ref_rx_latch <= slot_timestamp;
          ref_dist_latch <= slot_distance;
        end
      end
      if (cmd.commit) begin
        if (seq_ok) clock_ratio[an_i] <= new_ratio;
        stored_seq[an_i] <= seq;
        stored_tx_time[an_i] <= own_tx_latch;
        stored_arrival[an_i] <= arrival;
        previous_anchor <= an;
        own_tx_latch <= '0;
        ref_rx_latch <= '0;
        ref_dist_latch <= '0;
      end
    end
  end

  logic meas_ok;
  logic [7:0] want;

  assign want = (previous_anchor < an) ? seq : 8'(seq - 8'd1);
  assign tdiff_wide = $signed({2'b0, prod[63:30]})
    - 36'(signed'(32'({16'd0, ref_dist_latch} + own_tx_latch - ref_rx_latch)));

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      an <= anchor_id;
      seq <= packet_seq;
      arrival <= arrival_time;
      seq_ok <= (packet_seq == stored_seq[AW'(anchor_id)] + 8'd1);
      f_t <= arrival_time - stored_arrival[AW'(anchor_id)];
      rem <= '0;
      quot <= '0;
      div_cnt <= '0;
    end
    if (cmd.div_step && div_cnt == 6'd0 && !cmd.load) begin
      dividend <= {1'b0, own_tx_latch - stored_tx_time[an_i], 30'd0};
      div_cnt <= 6'd1;
    end else if (cmd.div_step) begin
      // restoring divide, one quotient bit per cycle
      if (shifted >= {31'd0, f_t}) begin
        rem <= shifted - {31'd0, f_t};
        quot <= {quot[61:0], 1'b1};
      end else begin
        rem <= shifted;
        quot <= {quot[61:0], 1'b0};
      end
      dividend <= {dividend[61:0], 1'b0};
      div_cnt <= div_cnt + 6'd1;
    end
    if (cmd.mul1) begin
      prod <= 64'(arrival - stored_arrival[ar_i]) * 64'(ratio_use);
      meas_ok <= (an != previous_anchor) && ({2'b0, previous_anchor} < 5'(ANCHORS))
        && (stored_seq[ar_i] == want) && (ref_dist_latch != 0)
        && (ref_rx_latch != 0) && (ratio_use != 0);
    end
    if (cmd.mul2) begin
      if (tdiff_wide > 36'sd2147483647) tdiff <= 32'sh7FFFFFFF;
      else if (tdiff_wide < -36'sd2147483648) tdiff <= 32'sh80000000;
      else tdiff <= tdiff_wide[31:0];
    end
    if (cmd.mul3) begin
      tneg <= tdiff[31];
      mprod <= 64'($unsigned(tdiff[31] ? -tdiff : tdiff)) * 64'(scale);
    end
  end

  logic [47:0] mag;
  logic signed [40:0] dd;
  always_comb begin
    if (tneg) begin
      mag = 48'((mprod + 64'hFFFF) >> 16);
      dd = (mag > 48'd1099511627776) ? 41'sh10000000000 : -41'(mag);
    end else begin
      mag = 48'(mprod >> 16);
      dd = (mag > 48'd1099511627775) ? 41'sh0FFFFFFFFFF : 41'(mag);
    end
    result = {meas_ok ? dd : 41'd0, meas_ok ? tdiff : 32'd0, an, previous_anchor,
              !seq_ok, meas_ok};
  end
endmodule
`default_nettype wire

@@ sv/tdoa_measurement_engine.sv @@
// Channel  | Dir | Content
// s_axis   | in  | tdata: anchor_id, packet_seq, arrival_time, slot, slot_timestamp,
//          |     |        slot_distance; tlast: last_slot
// m_axis   | out | tdata: measurement_valid .. distance_diff
// cfg      | in  | cfg_wdata: tick_to_metre_scale
// A slot item that is not the last, or whose anchor is out of range, keeps s_axis_tready
// high. An in-range last slot holds s_axis_tready low after it is taken, through the
// bit-serial ratio divider (a dividend load step and 63 quotient bits), three multiply and
// saturation steps, and the output hand-off. Reset is synchronous and clears all tables.
// The output register holds a result while m_axis_tready is low; a finished last
// slot waits in the hand-off step until it is free.
`default_nettype none
`include "assert_macros.svh"
module tdoa_measurement_engine #(
  parameter int ANCHORS = 8
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         cfg_we,
  input  wire logic [31:0]  cfg_wdata,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  // anchor_id[2:0], packet_seq[10:3], arrival_time[42:11], slot[45:43],
  // slot_timestamp[77:46], slot_distance[93:78], zero fill
  input  wire logic [95:0]  s_axis_tdata,
  input  wire logic         s_axis_tlast,
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  // measurement_valid[0], seq_rejected[1], reference_anchor[4:2],
  // current_anchor[7:5], time_diff_ticks[39:8], distance_diff[80:40], zero fill
  output logic [87:0]       m_axis_tdata
);
  logic [31:0] scale;
  tdoa_pkg::cmd_t cmd;
  tdoa_pkg::stat_t stat;
  logic busy, out_set, in_fire, out_free;
  logic [80:0] result;

  always_ff @(posedge clk) begin
    if (rst) scale <= tdoa_pkg::SCALE_RESET;
    else if (cfg_we) scale <= cfg_wdata;
  end

  assign s_axis_tready = !busy;
  assign in_fire = s_axis_tvalid && s_axis_tready;
  assign out_free = !m_axis_tvalid || m_axis_tready;

  tdoa_ctrl u_ctrl (.clk, .rst, .in_fire, .out_free, .stat, .cmd, .busy, .out_set);

  tdoa_dp #(.ANCHORS(ANCHORS)) u_dp (
    .clk, .rst, .cmd, .stat, .scale,
    .anchor_id(s_axis_tdata[2:0]), .packet_seq(s_axis_tdata[10:3]),
    .arrival_time(s_axis_tdata[42:11]), .slot(s_axis_tdata[45:43]),
    .slot_timestamp(s_axis_tdata[77:46]), .slot_distance(s_axis_tdata[93:78]),
    .last_slot(s_axis_tlast), .result
  );

  always_ff @(posedge clk) begin
    if (rst) m_axis_tvalid <= 1'b0;
    else if (out_set) m_axis_tvalid <= 1'b1;
    else if (m_axis_tready) m_axis_tvalid <= 1'b0;
  end
  always_ff @(posedge clk) begin
    if (out_set) m_axis_tdata <= {7'd0, result};
  end

  `ASSERT_NEXT(a_out_hold, clk, rst, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)
  `ASSERT_IMPL(a_no_load_busy, clk, rst, busy |-> !cmd.load)
  `ASSERT_NEXT(a_set_valid, clk, rst, out_set, m_axis_tvalid)
endmodule
`default_nettype wire
